/* rtl/gray_world_white_balance_assert.svh */
// Assertion macros shared by the gray-world white balance RTL.
`ifndef GRAY_WORLD_WHITE_BALANCE_ASSERT_SVH
`define GRAY_WORLD_WHITE_BALANCE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GW_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GW_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/gwwb_pkg.sv */
// Shared types, constants and helpers for the gray-world white balance block.
package gwwb_pkg;
    localparam int PIX_W       = 8;
    localparam int TOTAL_W     = 29;
    localparam int MEAN_SHIFT_DEF = 21;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] UNITY   = 8'd128;
    localparam int QW    = 16;  // product width value*target
    localparam int QUEUE_DEPTH = 2;

    // One pixel as handed from the front end to the divider back end.
    typedef struct packed {
        logic [QW-1:0]    num_r;
        logic [QW-1:0]    num_g;
        logic [QW-1:0]    num_b;
        logic [PIX_W-1:0] den_r;
        logic [PIX_W-1:0] den_g;
        logic [PIX_W-1:0] den_b;
        logic             done;
        logic [PIX_W-1:0] avg_r;
        logic [PIX_W-1:0] avg_g;
        logic [PIX_W-1:0] avg_b;
        logic [PIX_W-1:0] avg_t;
    } gwwb_job_t;
endpackage

/* rtl/gwwb_front.sv */
// Front end: takes pixels, forms products, keeps totals and frame means.
module gwwb_front #(
    parameter int MEAN_SHIFT = gwwb_pkg::MEAN_SHIFT_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_red_in,
    input  logic [7:0]               s_green_in,
    input  logic [7:0]               s_blue_in,
    input  logic                     s_frame_end,
    output logic                     job_valid,
    input  logic                     job_ready,
    output gwwb_pkg::gwwb_job_t      job
);
    import gwwb_pkg::*;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    // A sum of three means is at most 765; 683 / 2048 divides it by three exactly.
    localparam logic [19:0] THIRD_RECIP = 20'd683;
    localparam int          THIRD_SHIFT = 11;

    logic [TOTAL_W-1:0] tot_reg [3];
    logic [TOTAL_W-1:0] tot_next [3];
    logic [PIX_W-1:0]   avg_reg [3];
    logic [PIX_W-1:0]   tgt_reg;
    logic [PIX_W-1:0]   mean_new [3];
    logic [PIX_W-1:0]   tgt_new;
    logic [PIX_W-1:0]   pix [3];
    logic [PIX_W+1:0]   mean_sum;
    logic [19:0]        mean_third;
    logic               take;

    assign pix[0] = s_red_in;
    assign pix[1] = s_green_in;
    assign pix[2] = s_blue_in;
    assign s_ready = job_ready;
    assign job_valid = s_valid;
    assign take = s_valid && job_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [TOTAL_W:0]   s;
            logic [TOTAL_W-1:0] m;
            s = {1'b0, tot_reg[i]} + {{(TOTAL_W-PIX_W+1){1'b0}}, pix[i]};
            tot_next[i] = s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
            m = tot_next[i] >> MEAN_SHIFT;
            mean_new[i] = (m > TOTAL_W'(PIX_MAX)) ? PIX_MAX : m[PIX_W-1:0];
        end
        mean_sum = {2'b0, mean_new[0]} + {2'b0, mean_new[1]} + {2'b0, mean_new[2]};
        mean_third = {10'b0, mean_sum} * THIRD_RECIP;
        tgt_new = mean_third[THIRD_SHIFT+PIX_W-1:THIRD_SHIFT];
    end

    always_comb begin
        job.num_r = QW'(s_red_in) * QW'(tgt_reg);
        job.num_g = QW'(s_green_in) * QW'(tgt_reg);
        job.num_b = QW'(s_blue_in) * QW'(tgt_reg);
        job.den_r = avg_reg[0];
        job.den_g = avg_reg[1];
        job.den_b = avg_reg[2];
        job.done  = s_frame_end;
        job.avg_r = s_frame_end ? mean_new[0] : '0;
        job.avg_g = s_frame_end ? mean_new[1] : '0;
        job.avg_b = s_frame_end ? mean_new[2] : '0;
        job.avg_t = s_frame_end ? tgt_new : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                tot_reg[i] <= '0;
                avg_reg[i] <= UNITY;
            end
            tgt_reg <= UNITY;
        end else if (take) begin
            for (int i = 0; i < 3; i++) begin
                tot_reg[i] <= s_frame_end ? '0 : tot_next[i];
                if (s_frame_end) avg_reg[i] <= mean_new[i];
            end
            if (s_frame_end) tgt_reg <= tgt_new;
        end
    end
endmodule

/* rtl/gwwb_queue.sv */
// Two-entry queue between the front end and the divider.
module gwwb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  gwwb_pkg::gwwb_job_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gwwb_pkg::gwwb_job_t out_data
);
    import gwwb_pkg::*;

    gwwb_job_t mem_reg [QUEUE_DEPTH];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign in_ready  = (cnt_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

/* rtl/gwwb_divider.sv */
// Back end: three radix-2 dividers run side by side, one quotient bit per cycle.
module gwwb_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  gwwb_pkg::gwwb_job_t job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_red_out,
    output logic [7:0]          m_green_out,
    output logic [7:0]          m_blue_out,
    output logic                m_frame_done,
    output logic [7:0]          m_red_avg_out,
    output logic [7:0]          m_green_avg_out,
    output logic [7:0]          m_blue_avg_out,
    output logic [7:0]          m_target_avg_out
);
    import gwwb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

    state_t           state_reg;
    logic [3:0]       step_reg;
    gwwb_job_t        job_reg;
    logic [QW-1:0]    quo_reg [3];
    logic [PIX_W:0]   rem_reg [3];
    logic [QW-1:0]    num [3];
    logic [PIX_W-1:0] den [3];
    logic [QW-1:0]    quo_next [3];
    logic [PIX_W:0]   rem_next [3];
    logic [PIX_W-1:0] res [3];

    assign num[0] = job_reg.num_r;
    assign num[1] = job_reg.num_g;
    assign num[2] = job_reg.num_b;
    assign den[0] = job_reg.den_r;
    assign den[1] = job_reg.den_g;
    assign den[2] = job_reg.den_b;
    assign job_ready = (state_reg == S_IDLE);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [PIX_W+1:0] t;
            t = {rem_reg[i], quo_reg[i][QW-1]};
            if (t >= {2'b0, den[i]}) begin
                t = t - {2'b0, den[i]};
                quo_next[i] = {quo_reg[i][QW-2:0], 1'b1};
            end else begin
                quo_next[i] = {quo_reg[i][QW-2:0], 1'b0};
            end
            rem_next[i] = t[PIX_W:0];
            if (den[i] == '0 || quo_reg[i][QW-1:PIX_W] != '0) res[i] = PIX_MAX;
            else res[i] = quo_reg[i][PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job;
                        quo_reg[0] <= job.num_r;
                        quo_reg[1] <= job.num_g;
                        quo_reg[2] <= job.num_b;
                        for (int i = 0; i < 3; i++) rem_reg[i] <= '0;
                        step_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        quo_reg[i] <= quo_next[i];
                        rem_reg[i] <= rem_next[i];
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(QW-1)) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid          <= 1'b1;
                        m_red_out        <= res[0];
                        m_green_out      <= res[1];
                        m_blue_out       <= res[2];
                        m_frame_done     <= job_reg.done;
                        m_red_avg_out    <= job_reg.avg_r;
                        m_green_avg_out  <= job_reg.avg_g;
                        m_blue_avg_out   <= job_reg.avg_b;
                        m_target_avg_out <= job_reg.avg_t;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (m_valid && m_ready && !(state_reg == S_OUT)) m_valid <= 1'b0;
        end
    end
endmodule

/* rtl/gray_world_white_balance.sv */
// Top level of the gray-world white balance block.
// Gray-world white balance on an RGB pixel stream. Each pixel is scaled channel by channel
// by target/mean, using the means of the previous frame, saturating at 255 (and giving 255
// when a mean is zero). The pixel carrying frame_end closes the frame: the new means and
// their average appear on that transaction's result. The front end accepts a pixel in
// every cycle while the two-entry queue has room; the back end divides with three
// radix-2 dividers and takes no new pixel until it has handed on its last result,
// so the divider sets the sustained rate. Results leave in input order.
module gray_world_white_balance #(
    parameter int MEAN_SHIFT = gwwb_pkg::MEAN_SHIFT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_blue_in,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    output logic       m_frame_done,
    output logic [7:0] m_red_avg_out,
    output logic [7:0] m_green_avg_out,
    output logic [7:0] m_blue_avg_out,
    output logic [7:0] m_target_avg_out
);
    import gwwb_pkg::*;
`include "gray_world_white_balance_assert.svh"

    gwwb_job_t f_job, q_job;
    logic      f_valid, f_ready, q_valid, q_ready;

    // The front end takes the transaction and updates totals and means at once.
    gwwb_front #(.MEAN_SHIFT(MEAN_SHIFT)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_red_in, .s_green_in, .s_blue_in,
        .s_frame_end, .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    // The queue lets the pixel stream continue while the divider works.
    gwwb_queue u_queue (
        .aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_job)
    );

    gwwb_divider u_div (
        .aclk, .aresetn, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .m_valid, .m_ready, .m_red_out, .m_green_out, .m_blue_out, .m_frame_done,
        .m_red_avg_out, .m_green_avg_out, .m_blue_avg_out, .m_target_avg_out
    );

    // Means are reported only on a result that closes a frame.
    `GW_ASSERT_IMP(a_avg_zero, aclk, aresetn, m_valid && !m_frame_done,
        m_red_avg_out == 8'd0 && m_target_avg_out == 8'd0)
    // The front end never pushes into a full queue.
    `GW_ASSERT_IMP(a_no_overflow, aclk, aresetn, f_valid && !f_ready, !s_ready)
    // A result waiting on the output holds its value.
    `GW_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_red_out))
endmodule

/* dv/tb_gray_world_white_balance.sv */
// Self-checking testbench for the gray-world white balance block.
module tb_gray_world_white_balance;
    import gwwb_pkg::*;

    // The block keeps its means at eight bits; totals saturate at the total width.
    localparam int SHIFT = MEAN_SHIFT_DEF;
    localparam logic [TOTAL_W-1:0] TOTAL_CEIL = '1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER = 40;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } pixel_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       done;
        logic [7:0] mr;
        logic [7:0] mg;
        logic [7:0] mb;
        logic [7:0] mt;
    } balanced_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_red_in;
    logic [7:0] s_green_in;
    logic [7:0] s_blue_in;
    logic       s_frame_end;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_red_out;
    logic [7:0] m_green_out;
    logic [7:0] m_blue_out;
    logic       m_frame_done;
    logic [7:0] m_red_avg_out;
    logic [7:0] m_green_avg_out;
    logic [7:0] m_blue_avg_out;
    logic [7:0] m_target_avg_out;

    gray_world_white_balance i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_frame_done    (m_frame_done),
        .m_red_avg_out   (m_red_avg_out),
        .m_green_avg_out (m_green_avg_out),
        .m_blue_avg_out  (m_blue_avg_out),
        .m_target_avg_out(m_target_avg_out)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Pixels waiting to be offered, and balanced pixels still owed by the block.
    pixel_t    pending_pixels[$];
    balanced_t owed_pixels[$];

    // The predictor's own copy of the block's state.
    logic [TOTAL_W-1:0] sum_r, sum_g, sum_b;
    logic [7:0]         mean_r, mean_g, mean_b, mean_t;

    int  mismatches;
    int  idle_cycles;
    int  results_seen;
    int  hold_count;
    int  recv_gap;
    int  recv_draw;
    bit  hold_done;
    bit  stimulus_loaded;
    bit  hold_off_request;
    balanced_t want_pixel;
    balanced_t got_pixel;

    // Gain of one channel: value * target / mean, truncated, saturating at 255;
    // a zero mean gives full scale whatever the input.
    function automatic logic [7:0] scale_value(logic [7:0] v, logic [7:0] m, logic [7:0] t);
        logic [15:0] q;
        if (m == 8'd0) begin
            return PIX_MAX;
        end
        q = (16'(v) * 16'(t)) / 16'(m);
        return (q > 16'(PIX_MAX)) ? PIX_MAX : q[7:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] add_sat(logic [TOTAL_W-1:0] s, logic [7:0] v);
        logic [TOTAL_W:0] w;
        w = {1'b0, s} + (TOTAL_W + 1)'(v);
        return w[TOTAL_W] ? TOTAL_CEIL : w[TOTAL_W-1:0];
    endfunction

    function automatic logic [7:0] mean_from(logic [TOTAL_W-1:0] s);
        logic [TOTAL_W-1:0] m;
        m = s >> SHIFT;
        return (m > TOTAL_W'(PIX_MAX)) ? PIX_MAX : m[7:0];
    endfunction

    // Works out the balanced pixel for one accepted transaction and advances the state.
    function automatic balanced_t balance_pixel(pixel_t p);
        balanced_t o;
        logic [9:0] three;
        o      = '0;
        o.r    = scale_value(p.r, mean_r, mean_t);
        o.g    = scale_value(p.g, mean_g, mean_t);
        o.b    = scale_value(p.b, mean_b, mean_t);
        sum_r  = add_sat(sum_r, p.r);
        sum_g  = add_sat(sum_g, p.g);
        sum_b  = add_sat(sum_b, p.b);
        if (p.last) begin
            mean_r = mean_from(sum_r);
            mean_g = mean_from(sum_g);
            mean_b = mean_from(sum_b);
            three  = 10'(mean_r) + 10'(mean_g) + 10'(mean_b);
            mean_t = 8'(three / 10'd3);
            sum_r  = '0;
            sum_g  = '0;
            sum_b  = '0;
            o.done = 1'b1;
            o.mr   = mean_r;
            o.mg   = mean_g;
            o.mb   = mean_b;
            o.mt   = mean_t;
        end
        return o;
    endfunction

    function automatic pixel_t make_pixel(int r, int g, int b, bit last);
        pixel_t p;
        p.r    = 8'(r);
        p.g    = 8'(g);
        p.b    = 8'(b);
        p.last = last;
        return p;
    endfunction

    // Stimulus. The first frame runs at unity gain. With a shift of 21 a mean stays
    // zero unless a frame holds more than 8224 full-value pixels, so every frame after
    // the first closes with zero means and the outputs saturate. Random frames of
    // random length follow the directed pixels.
    initial begin
        int n;
        int len;
        sum_r  = '0;
        sum_g  = '0;
        sum_b  = '0;
        mean_r = UNITY;
        mean_g = UNITY;
        mean_b = UNITY;
        mean_t = UNITY;
        pending_pixels.push_back(make_pixel(0, 0, 0, 0));
        pending_pixels.push_back(make_pixel(255, 255, 255, 0));
        pending_pixels.push_back(make_pixel(1, 128, 254, 0));
        pending_pixels.push_back(make_pixel(170, 85, 15, 0));
        // Short frame: every mean becomes zero and the next outputs saturate.
        pending_pixels.push_back(make_pixel(240, 15, 60, 1));
        pending_pixels.push_back(make_pixel(0, 0, 0, 0));
        pending_pixels.push_back(make_pixel(77, 200, 3, 1));
        n = 0;
        while (n < 400) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                pending_pixels.push_back(make_pixel($urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    (i == len - 1) || ($urandom_range(0, 30) == 0)));
                n++;
            end
        end
        stimulus_loaded = 1'b1;
    end

    // Driver: offers the next pending pixel after a random number of idle cycles.
    // The pixel on offer stays at the head of the queue until it is accepted.
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_red_in    <= '0;
            s_green_in  <= '0;
            s_blue_in   <= '0;
            s_frame_end <= 1'b0;
            send_gap    <= $urandom_range(0, 3);
        end else if (s_valid && !s_ready) begin
            // hold the transaction until the block takes it
        end else begin
            if (s_valid) begin
                owed_pixels.push_back(balance_pixel(pending_pixels.pop_front()));
            end
            if (pending_pixels.size() > 0 && send_gap == 0) begin
                pixel_t p;
                p = pending_pixels[0];
                s_valid     <= 1'b1;
                s_red_in    <= p.r;
                s_green_in  <= p.g;
                s_blue_in   <= p.b;
                s_frame_end <= p.last;
                send_gap    <= $urandom_range(0, 3);
            end else begin
                s_valid  <= 1'b0;
                send_gap <= (send_gap > 0) ? send_gap - 1 : 0;
            end
        end
    end

    // Long hold-off on the result side once some results have gone by, so that the
    // queue fills and the input stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_off_request <= 1'b0;
            hold_count       <= 0;
            hold_done        <= 1'b0;
        end else if (hold_off_request) begin
            if (hold_count == HOLD_OFF_CYCLES - 1) begin
                hold_off_request <= 1'b0;
                hold_done        <= 1'b1;
            end
            hold_count <= hold_count + 1;
        end else if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
            hold_off_request <= 1'b1;
        end
    end

    // Receiver: waits a random number of cycles before each result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else if (hold_off_request) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            recv_draw = $urandom_range(0, 3);
            recv_gap <= recv_draw;
            m_ready  <= (recv_draw == 0);
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready  <= (recv_gap == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: compares each accepted result with the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_pixel = {m_red_out, m_green_out, m_blue_out, m_frame_done,
                         m_red_avg_out, m_green_avg_out, m_blue_avg_out,
                         m_target_avg_out};
            if (owed_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected none, actual %h", results_seen,
                             got_pixel);
                end
            end else begin
                want_pixel = owed_pixels.pop_front();
                if (got_pixel !== want_pixel) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected %h, actual %h", results_seen,
                                 want_pixel, got_pixel);
                    end
                end
            end
            results_seen++;
        end
    end

    // Watchdog and end of run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (stimulus_loaded && pending_pixels.size() == 0 &&
                owed_pixels.size() == 0 && !s_valid) begin
                if (mismatches == 0) begin
                    $display("tb_gray_world_white_balance: clean");
                end else begin
                    $display("tb_gray_world_white_balance: errors");
                end
                $finish;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_gray_world_white_balance: errors");
                $finish;
            end
        end
    end
endmodule
